### sv/utf8d_pkg.sv
// Shared types, constants and helpers for the UTF-8 code point decoder.
// No dependencies; used by every module of the decoder.
package utf8d_pkg;

    localparam int CP_W   = 21;   // code point width
    localparam int BYTE_W = 8;    // input byte width
    localparam int CNT_W  = 3;    // results per byte, 0 to 4
    localparam int LEN_W  = 3;    // sequence length, 0 to 4
    localparam int REM_W  = 2;    // continuation bytes still expected

    localparam logic [CP_W-1:0]   MAX_CP_RESET = 21'h10FFFF;
    localparam logic [BYTE_W-1:0] LEAD_MAX     = 8'hF7;
    localparam logic [BYTE_W-1:0] LEAD4_MIN    = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_MIN    = 8'hE0;
    localparam logic [1:0]        CONT_TAG     = 2'b10;

    // Results of one byte: count words, all errors but the final one,
    // which carries cp (or an error when last_err is set).
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [CP_W-1:0]  cp;
        logic             last_err;
    } result_t;

    // Smallest value that is not overlong for a sequence of this length
    function automatic logic [CP_W-1:0] min_value(input logic [LEN_W-1:0] len);
        logic [CP_W-1:0] v;
        case (len)
            3'd2:    v = 21'h000080;
            3'd3:    v = 21'h000800;
            3'd4:    v = 21'h010000;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### sv/utf8d_step.sv
// Sequence state registers and the per-byte decode logic.
// Depends on utf8d_pkg.
module utf8d_step (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         advance,
    input  logic [utf8d_pkg::BYTE_W-1:0] byte_in,
    input  logic [utf8d_pkg::CP_W-1:0]   max_cp,
    output utf8d_pkg::result_t           res
);

    logic [utf8d_pkg::CP_W-1:0]  bits_reg, bits_next;
    logic [utf8d_pkg::REM_W-1:0] rem_reg, rem_next;
    logic [utf8d_pkg::LEN_W-1:0] len_reg, len_next;

    // Decode one byte against the open sequence
    always_comb begin
        logic                        lead_ascii;
        logic                        lead_bad;
        logic                        is_cont;
        logic [utf8d_pkg::LEN_W-1:0] lead_len;
        logic [utf8d_pkg::CP_W-1:0]  lead_bits;
        logic [utf8d_pkg::CP_W-1:0]  cont_bits;
        logic [utf8d_pkg::REM_W-1:0] consumed;
        logic [utf8d_pkg::REM_W-1:0] rem_dec;
        logic [utf8d_pkg::CNT_W-1:0] err_cnt;

        is_cont    = (byte_in[7:6] == utf8d_pkg::CONT_TAG);
        lead_ascii = !byte_in[7];
        lead_bad   = (byte_in > utf8d_pkg::LEAD_MAX) || is_cont;
        if (byte_in >= utf8d_pkg::LEAD4_MIN) begin
            lead_len = 3'd4;
        end else if (byte_in >= utf8d_pkg::LEAD3_MIN) begin
            lead_len = 3'd3;
        end else begin
            lead_len = 3'd2;
        end
        case (lead_len)
            3'd4:    lead_bits = {18'd0, byte_in[2:0]};
            3'd3:    lead_bits = {17'd0, byte_in[3:0]};
            default: lead_bits = {16'd0, byte_in[4:0]};
        endcase
        cont_bits = {bits_reg[utf8d_pkg::CP_W-7:0], byte_in[5:0]};
        consumed  = len_reg[1:0] - 2'd1 - rem_reg;
        rem_dec   = rem_reg - 2'd1;
        err_cnt   = 3'd1 + {1'b0, consumed};

        bits_next    = bits_reg;
        rem_next     = rem_reg;
        len_next     = len_reg;
        res.count    = '0;
        res.cp       = '0;
        res.last_err = 1'b1;

        if (rem_reg == '0) begin
            // No sequence open: take the byte as a lead
            if (lead_ascii) begin
                res.count    = 3'd1;
                res.cp       = {13'd0, byte_in};
                res.last_err = 1'b0;
            end else if (lead_bad) begin
                res.count = 3'd1;
            end else begin
                bits_next = lead_bits;
                len_next  = lead_len;
                rem_next  = lead_len[1:0] - 2'd1;
            end
        end else if (!is_cont) begin
            // Abort: error for the lead and each consumed byte, then relead
            bits_next = '0;
            rem_next  = '0;
            len_next  = '0;
            if (lead_ascii) begin
                res.count    = err_cnt + 3'd1;
                res.cp       = {13'd0, byte_in};
                res.last_err = 1'b0;
            end else if (lead_bad) begin
                res.count = err_cnt + 3'd1;
            end else begin
                res.count = err_cnt;
                bits_next = lead_bits;
                len_next  = lead_len;
                rem_next  = lead_len[1:0] - 2'd1;
            end
        end else if (rem_dec != '0) begin
            // Gather six more value bits
            bits_next = cont_bits;
            rem_next  = rem_dec;
        end else begin
            // Close the sequence and check overlong form and range
            bits_next = '0;
            rem_next  = '0;
            len_next  = '0;
            if (cont_bits < utf8d_pkg::min_value(len_reg) || cont_bits > max_cp) begin
                res.count = len_reg;
            end else begin
                res.count    = 3'd1;
                res.cp       = cont_bits;
                res.last_err = 1'b0;
            end
        end
    end

    // Advance the sequence state when the byte moves on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bits_reg <= '0;
            rem_reg  <= '0;
            len_reg  <= '0;
        end else if (advance) begin
            bits_reg <= bits_next;
            rem_reg  <= rem_next;
            len_reg  <= len_next;
        end
    end

endmodule

### sv/utf8d_out_stage.sv
// Result register: holds a byte's results, hands out one word a cycle while m_tready.
// Depends on utf8d_pkg.
module utf8d_out_stage (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       load,
    input  utf8d_pkg::result_t         res,
    output logic                       free,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [23:0]                m_tdata,
    output logic                       m_tuser,
    output logic                       m_tlast
);

    logic [utf8d_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [utf8d_pkg::CP_W-1:0]  cp_reg;
    logic                        err_reg;
    logic                        final_word;

    assign final_word = (cnt_reg == 3'd1);
    assign m_tvalid   = (cnt_reg != '0);
    assign free       = (cnt_reg == '0) || (m_tready && final_word);

    // Leading words are errors; the final word carries the stored result
    assign m_tdata = {3'd0, final_word ? cp_reg : {utf8d_pkg::CP_W{1'b0}}};
    assign m_tuser = final_word ? err_reg : 1'b1;
    assign m_tlast = final_word;

    // Load a new byte's results or count down on each word taken
    always_comb begin
        cnt_next = cnt_reg;
        if (load) begin
            cnt_next = res.count;
        end else if (m_tvalid && m_tready) begin
            cnt_next = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // Hold the payload of the final word
    always_ff @(posedge aclk) begin
        if (load) begin
            cp_reg  <= res.cp;
            err_reg <= res.last_err;
        end
    end

endmodule

### sv/utf8_codepoint_decoder_unit.sv
// Top level of the UTF-8 code point decoder: input register, config register, glue.
// Depends on utf8d_pkg, utf8d_step and utf8d_out_stage.
//
//  channel | dir | handshake            | payload
//  s_      | in  | s_tvalid / s_tready  | s_tdata[7:0] byte_in
//  m_      | out | m_tvalid / m_tready  | m_tdata[20:0] code_point, m_tuser is_error,
//          |     |                      | m_tlast last
//  cfg_    | in  | cfg_valid/cfg_ready  | cfg_data[20:0] max_codepoint
//
// One byte a cycle unless the result register holds it back: a byte waits in the
// input register, is decoded and lands in the result register. A byte with results
// holds the decoder while they are handed out; bytes with none pass freely.
// Reset (aresetn, synchronous) closes any open sequence and sets max_codepoint to
// 0x10FFFF. A stall on m_ backs up into s_tready through the input register.
module utf8_codepoint_decoder_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] byte_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,     // [20:0] code_point, [23:21] zero
    output logic        m_tuser,     // [0] is_error
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [20:0] cfg_data     // [20:0] max_codepoint
);

    logic                         in_valid_reg;
    logic [utf8d_pkg::BYTE_W-1:0] in_byte_reg;
    logic [utf8d_pkg::CP_W-1:0]   max_cp_reg;
    logic                         advance;
    logic                         out_free;
    utf8d_pkg::result_t           res;

    assign cfg_ready = 1'b1;

    // Hold the largest accepted code point
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_cp_reg <= utf8d_pkg::MAX_CP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            max_cp_reg <= cfg_data;
        end
    end

    // Move the byte on when its results fit or it has none
    assign advance  = in_valid_reg && ((res.count == '0) || out_free);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    utf8d_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .byte_in (in_byte_reg),
        .max_cp  (max_cp_reg),
        .res     (res)
    );

    utf8d_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && (res.count != '0)),
        .res      (res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Only the final word of a byte can carry a code point
    a_lead_words_err: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> m_tuser)
        else $error("non-final result word is not an error");

    // Error words carry a zero code point
    a_err_zero_cp: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[20:0] == 21'd0))
        else $error("error word with non-zero code point");

    // A byte held back in the input register is kept
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("stalled input byte lost or changed");

endmodule
